>>> hw/rtl/svpwm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svpwm_pkg
// shared types and constants of the space vector pwm core
// ----------------------------------------------------------------------------
package svpwm_pkg;

    localparam int DUTY_FRAC_BITS_DEF = 15;

    localparam logic [15:0] MAX_DUTY_RST = 16'd32768;
    localparam logic [15:0] MID_DUTY_RST = 16'd31130;
    localparam logic [15:0] MIN_DUTY_RST = 16'd1638;

    localparam logic [1:0] REG_MAX_DUTY = 2'd0;
    localparam logic [1:0] REG_MID_DUTY = 2'd1;
    localparam logic [1:0] REG_MIN_DUTY = 2'd2;

    localparam logic signed [17:0] SQRT3_Q16 = 18'sd113512;

    localparam int IN_WORD_W  = 56;
    localparam int OUT_WORD_W = 56;

    typedef logic [1:0] slot_map_t [8];

    localparam slot_map_t MAP_A = '{2'd0, 2'd1, 2'd0, 2'd0, 2'd2, 2'd2, 2'd1, 2'd0};
    localparam slot_map_t MAP_B = '{2'd0, 2'd0, 2'd2, 2'd1, 2'd1, 2'd0, 2'd2, 2'd0};
    localparam slot_map_t MAP_C = '{2'd0, 2'd2, 2'd1, 2'd2, 2'd0, 2'd1, 2'd0, 2'd0};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PROD,
        ST_DIFF,
        ST_T1,
        ST_T2,
        ST_SUM,
        ST_DIV,
        ST_SLOT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic prod;
        logic diff;
        logic mul_t1;
        logic mul_t2;
        logic sum;
        logic div_step;
        logic slot;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic scale;
        logic out_free;
    } dp_status_t;

endpackage
`default_nettype wire

>>> hw/rtl/svpwm_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svpwm_cfg
// apb register file holding the duty limits
// ----------------------------------------------------------------------------
module svpwm_cfg (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output logic      [15:0] max_duty,
    output logic      [15:0] mid_duty,
    output logic      [15:0] min_duty
);
    import svpwm_pkg::*;

    logic [15:0] max_reg;
    logic [15:0] mid_reg;
    logic [15:0] min_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg <= MAX_DUTY_RST;
            mid_reg <= MID_DUTY_RST;
            min_reg <= MIN_DUTY_RST;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                REG_MAX_DUTY: max_reg <= pwdata[15:0];
                REG_MID_DUTY: mid_reg <= pwdata[15:0];
                REG_MIN_DUTY: min_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_MAX_DUTY: prdata = {16'd0, max_reg};
            REG_MID_DUTY: prdata = {16'd0, mid_reg};
            REG_MIN_DUTY: prdata = {16'd0, min_reg};
            default:      prdata = 32'd0;
        endcase
    end

    assign max_duty = max_reg;
    assign mid_duty = mid_reg;
    assign min_duty = min_reg;

endmodule
`default_nettype wire

>>> hw/rtl/svpwm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svpwm_ctrl
// sequencer stepping the datapath through one pwm period
// ----------------------------------------------------------------------------
module svpwm_ctrl #(
    parameter int DUTY_FRAC_BITS = svpwm_pkg::DUTY_FRAC_BITS_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire svpwm_pkg::dp_status_t  status,
    output svpwm_pkg::dp_cmd_t          cmd
);
    import svpwm_pkg::*;

    localparam int MDW = DUTY_FRAC_BITS + 1;
    localparam int CW  = $clog2(MDW);
    localparam logic [CW-1:0] CNT_TOP = CW'(MDW - 1);

    state_t        state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE: if (in_valid) state_next = ST_PROD;
            ST_PROD: state_next = ST_DIFF;
            ST_DIFF: state_next = ST_T1;
            ST_T1:   state_next = ST_T2;
            ST_T2:   state_next = ST_SUM;
            ST_SUM:
            begin
                cnt_next   = CNT_TOP;
                state_next = status.scale ? ST_DIV : ST_SLOT;
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == '0) state_next = ST_SLOT;
            end
            ST_SLOT: state_next = ST_EMIT;
            ST_EMIT: if (status.out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_PROD: cmd.prod     = 1'b1;
            ST_DIFF: cmd.diff     = 1'b1;
            ST_T1:   cmd.mul_t1   = 1'b1;
            ST_T2:   cmd.mul_t2   = 1'b1;
            ST_SUM:  cmd.sum      = 1'b1;
            ST_DIV:  cmd.div_step = 1'b1;
            ST_SLOT: cmd.slot     = 1'b1;
            ST_EMIT: cmd.emit     = status.out_free;
            default: ;
        endcase
    end

endmodule
`default_nettype wire

>>> hw/rtl/svpwm_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svpwm_dp
// sector, active times, proportional scaling, duties and output register
// ----------------------------------------------------------------------------
module svpwm_dp #(
    parameter int DUTY_FRAC_BITS = svpwm_pkg::DUTY_FRAC_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire svpwm_pkg::dp_cmd_t                  cmd,
    output svpwm_pkg::dp_status_t                    status,
    input  wire logic [svpwm_pkg::IN_WORD_W-1:0]     in_data,
    input  wire logic [15:0]                         max_duty,
    input  wire logic [15:0]                         mid_duty,
    input  wire logic [15:0]                         min_duty,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [svpwm_pkg::OUT_WORD_W-1:0]         out_data
);
    import svpwm_pkg::*;

    localparam int F   = DUTY_FRAC_BITS;
    localparam int SH  = 33 - F;
    localparam int TW  = F + 19;
    localparam int MDW = F + 1;
    localparam int SW  = TW + 3;
    localparam logic [51:0] RND = 52'(1) << (SH - 1);
    localparam int DUTY_TOP = (F >= 16) ? 65535 : (1 << F);
    localparam int ZERO_THRESH = (3 * (1 << F) + 10) / 20;
    localparam logic signed [SW-1:0] TOP_S  = SW'(DUTY_TOP);
    localparam logic signed [SW-1:0] ZERO_S = SW'(ZERO_THRESH);

    logic signed [15:0] alpha_reg;
    logic signed [15:0] beta_reg;
    logic        [15:0] inv_reg;
    logic               req_reg;
    logic signed [33:0] pb_reg;
    logic signed [33:0] a3_reg;
    logic signed [35:0] d1_reg, d2_reg, d3_reg;
    logic        [2:0]  sector_reg;
    logic        [TW-1:0] t1_reg, t2_reg;
    logic        [TW:0]   sum_reg;
    logic        [TW:0]   rem_reg;
    logic        [MDW-1:0] quo_reg;
    logic        [MDW-1:0] m_reg;
    logic signed [SW-1:0] s0_reg, s1_reg, s2_reg;
    logic               five_mode_reg;
    logic               out_valid_reg;
    logic [OUT_WORD_W-1:0] out_data_reg;

    logic [15+F:0]   mx_w, md_w, mn_w;
    logic [MDW-1:0]  mx, md, mn;
    logic signed [17:0] alpha3;
    logic signed [35:0] pb_x, a3_x;
    logic signed [35:0] rsel1, rsel2;
    logic [34:0]     mop;
    logic [50:0]     prod;
    logic [51:0]     prod_rnd;
    logic [TW:0]     sum_w;
    logic [TW+1:0]   sum_ext, r_sh, r_a, r_b, r_c;
    logic            c1, c2, mbit;
    logic            scale;
    logic signed [SW-1:0] tt1, tt2, mx_s, md_s, mn_s, sum_s, t2_s, zz, fsum, ft2;
    logic signed [SW-1:0] n0, n1, n2;
    logic [15:0]     duty_a, duty_b, duty_c;

    function automatic logic [15:0] sat_duty(input logic signed [SW-1:0] v);
        logic [15:0] r;
        if (v < 0)
            r = 16'd0;
        else if (v > TOP_S)
            r = 16'(DUTY_TOP);
        else
            r = v[15:0];
        return r;
    endfunction

    function automatic logic signed [SW-1:0] pick(input logic [1:0] idx,
        input logic signed [SW-1:0] a, input logic signed [SW-1:0] b,
        input logic signed [SW-1:0] c);
        logic signed [SW-1:0] r;
        case (idx)
            2'd0:    r = a;
            2'd1:    r = b;
            default: r = c;
        endcase
        return r;
    endfunction

    // register values rescaled to duty units
    assign mx_w = {max_duty, {F{1'b0}}};
    assign md_w = {mid_duty, {F{1'b0}}};
    assign mn_w = {min_duty, {F{1'b0}}};
    assign mx   = mx_w[15+F:15];
    assign md   = md_w[15+F:15];
    assign mn   = mn_w[15+F:15];

    assign alpha3 = $signed({{2{alpha_reg[15]}}, alpha_reg})
                  + $signed({alpha_reg[15], alpha_reg, 1'b0});
    assign pb_x   = 36'(pb_reg);
    assign a3_x   = 36'(a3_reg);

    always_comb
    begin
        rsel1 = '0;
        rsel2 = '0;
        case (sector_reg)
            3'd3: begin rsel1 = d2_reg;  rsel2 = d1_reg;  end
            3'd1: begin rsel1 = -d2_reg; rsel2 = -d3_reg; end
            3'd5: begin rsel1 = d1_reg;  rsel2 = d3_reg;  end
            3'd4: begin rsel1 = -d1_reg; rsel2 = -d2_reg; end
            3'd6: begin rsel1 = d3_reg;  rsel2 = d2_reg;  end
            3'd2: begin rsel1 = -d3_reg; rsel2 = -d1_reg; end
            default: ;
        endcase
    end

    assign mop      = cmd.mul_t2 ? rsel2[34:0] : rsel1[34:0];
    assign prod     = 51'(mop) * 51'(inv_reg);
    assign prod_rnd = {1'b0, prod} + RND;

    // restoring step of floor(mid * t1 / sum)
    assign sum_ext = {1'b0, sum_reg};
    assign r_sh    = {rem_reg, 1'b0};
    assign c1      = r_sh >= sum_ext;
    assign r_a     = c1 ? r_sh - sum_ext : r_sh;
    assign mbit    = m_reg[MDW-1];
    assign r_b     = mbit ? r_a + (TW+2)'(t1_reg) : r_a;
    assign c2      = mbit && (r_b >= sum_ext);
    assign r_c     = c2 ? r_b - sum_ext : r_b;

    // active time sum straight from t1 and t2, valid from the sum step on
    assign sum_w = (TW+1)'(t1_reg) + (TW+1)'(t2_reg);
    assign scale = !five_mode_reg && (sum_w > (TW+1)'(md));

    assign mx_s  = $signed(SW'(mx));
    assign md_s  = $signed(SW'(md));
    assign mn_s  = $signed(SW'(mn));
    assign sum_s = $signed(SW'(sum_reg));
    assign t2_s  = $signed(SW'(t2_reg));
    assign tt1   = scale ? $signed(SW'(quo_reg)) : $signed(SW'(t1_reg));
    assign tt2   = scale ? md_s - $signed(SW'(quo_reg)) : t2_s;
    assign zz    = (mx_s - tt1 - tt2) >>> 1;
    assign fsum  = ((sum_s <<< 1) > ((md_s <<< 1) + mn_s)) ? mx_s
                 : ((sum_s > md_s) ? md_s : sum_s);
    assign ft2   = (t2_s > md_s) ? md_s : t2_s;

    always_comb
    begin
        if (five_mode_reg)
        begin
            n0 = fsum;
            n1 = ft2;
            n2 = '0;
        end
        else
        begin
            n2 = zz;
            n1 = zz + tt2;
            n0 = zz + tt2 + tt1;
        end
    end

    assign duty_a = sat_duty(pick(MAP_A[sector_reg], s0_reg, s1_reg, s2_reg));
    assign duty_b = sat_duty(pick(MAP_B[sector_reg], s0_reg, s1_reg, s2_reg));
    assign duty_c = sat_duty(pick(MAP_C[sector_reg], s0_reg, s1_reg, s2_reg));

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            alpha_reg <= in_data[15:0];
            beta_reg  <= in_data[31:16];
            inv_reg   <= in_data[47:32];
            req_reg   <= in_data[48];
        end
        if (cmd.prod)
        begin
            pb_reg <= 34'(beta_reg * SQRT3_Q16);
            a3_reg <= {alpha3[17:0], 16'd0};
        end
        if (cmd.diff)
        begin
            d1_reg     <= pb_x <<< 1;
            d2_reg     <= a3_x - pb_x;
            d3_reg     <= -a3_x - pb_x;
            sector_reg <= {(!(-a3_x - pb_x < 0)) && ((-a3_x - pb_x) != 0) && (inv_reg != 0),
                           (!(a3_x - pb_x < 0)) && ((a3_x - pb_x) != 0) && (inv_reg != 0),
                           (pb_reg > 0) && (inv_reg != 0)};
        end
        if (cmd.mul_t1)
            t1_reg <= prod_rnd[51:SH];
        if (cmd.mul_t2)
            t2_reg <= prod_rnd[51:SH];
        if (cmd.sum)
        begin
            sum_reg <= sum_w;
            rem_reg <= '0;
            quo_reg <= '0;
            m_reg   <= md;
        end
        if (cmd.div_step)
        begin
            rem_reg <= r_c[TW:0];
            quo_reg <= {quo_reg[MDW-2:0], 1'b0} + MDW'(c1) + MDW'(c2);
            m_reg   <= {m_reg[MDW-2:0], 1'b0};
        end
        if (cmd.slot)
        begin
            s0_reg <= n0;
            s1_reg <= n1;
            s2_reg <= n2;
        end
        if (cmd.emit)
            out_data_reg <= {4'd0, five_mode_reg, duty_c, duty_b, duty_a, sector_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            five_mode_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.emit)
            begin
                if (five_mode_reg)
                begin
                    if (!req_reg) five_mode_reg <= 1'b0;
                end
                else if (req_reg && (s2_reg < ZERO_S))
                    five_mode_reg <= 1'b1;
            end
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign status.scale    = scale;
    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;

endmodule
`default_nettype wire

>>> hw/rtl/svpwm_three_shunt_five_segment_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svpwm_three_shunt_five_segment_core
// space vector pwm duty generator with seven and five segment modulation
//
//   channel   dir  words
//   s_axis    in   alpha, beta, 1/vbus, five-segment request
//   m_axis    out  sector, three phase duties, five-segment flag
//   apb       in   max_duty, mid_duty, min_duty at 0x0, 0x4, 0x8
//
// one word steps through product, difference, t1, t2, sum, slot and emit;
// seven-segment scaling adds a DUTY_FRAC_BITS+1 bit serial divide before slot
// the next word is taken once the result sits in the output register
// the result register holds while m_axis_tready is low
// reset clears the mode flag and loads the register defaults
// ----------------------------------------------------------------------------
module svpwm_three_shunt_five_segment_core #(
    parameter int DUTY_FRAC_BITS = svpwm_pkg::DUTY_FRAC_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // volt_alpha, volt_beta, inv_bus_volt, five_request
    input  wire logic [svpwm_pkg::IN_WORD_W-1:0]   s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // sector, duty_a, duty_b, duty_c, five_active
    output logic [svpwm_pkg::OUT_WORD_W-1:0]       m_axis_tdata,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [3:0]                        paddr,
    input  wire logic [31:0]                       pwdata,
    output logic      [31:0]                       prdata,
    output logic                                   pready
);
    import svpwm_pkg::*;

    dp_cmd_t     cmd;
    dp_status_t  status;
    logic [15:0] max_duty, mid_duty, min_duty;

    svpwm_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .max_duty (max_duty),
        .mid_duty (mid_duty),
        .min_duty (min_duty)
    );

    svpwm_ctrl #(.DUTY_FRAC_BITS(DUTY_FRAC_BITS)) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    svpwm_dp #(.DUTY_FRAC_BITS(DUTY_FRAC_BITS)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (s_axis_tdata),
        .max_duty  (max_duty),
        .mid_duty  (mid_duty),
        .min_duty  (min_duty),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

`ifndef SYNTHESIS
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.out_free)
        else $error("result written over a pending word");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken while a word is in flight");

    a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !cmd.emit) |=> !m_axis_tvalid)
        else $error("result repeated after being taken");
`endif

endmodule
`default_nettype wire
